/* rtl/core/rsmc_pkg.sv */
// Shared types, codes and constants for the roller shutter motor controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package rsmc_pkg;

	localparam int TICK_MS_DEF = 10;     // default tick period in ms
	localparam int CFG_W       = 16;     // width of each configuration register
	localparam int CFG_IDX_W   = 2;
	localparam int POS_W       = 20;     // signed ms, covers both overrun ends for any tick
	localparam int MAG_W       = 18;     // magnitude bits of a positive position
	localparam int PCT_W       = 7;
	localparam int RPCT_W      = 8;
	localparam int DIV_W       = 24;     // dividend / quotient width of the divider
	localparam int QDEPTH      = 2;
	localparam int PCT_MAX     = 100;

	localparam logic [CFG_W-1:0] FULL_TRAVEL_RST = 16'd30000;
	localparam logic [CFG_W-1:0] OVERRUN_RST     = 16'd2000;
	localparam logic [CFG_W-1:0] REV_PAUSE_RST   = 16'd500;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_CMD     = 2'd1,
		MODE_RESTORE = 2'd2,
		MODE_RSVD    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		IN_OPEN    = 2'd0,
		IN_CLOSE   = 2'd1,
		IN_STOP    = 2'd2,
		IN_UNKNOWN = 2'd3
	} in_cmd_t;

	// pending command and motor direction share these codes
	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_CMD     = 2'd1,
		OP_RESTORE = 2'd2,
		OP_NOP     = 2'd3
	} op_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_TRAVEL = 2'd0,
		REG_OVERRUN     = 2'd1,
		REG_REV_PAUSE   = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_MOVE = 3'd1,
		ST_MUL  = 3'd2,
		ST_DIV  = 3'd3,
		ST_FIN  = 3'd4
	} state_t;

	// classified item handed from front to back; CMD_NONE on a command leaves pending as is
	typedef struct packed {
		op_kind_t           kind;
		cmd_t               cmd;
		logic [PCT_W-1:0]   pct;
	} op_t;

	typedef struct packed {
		logic [PCT_W-1:0] report_pct;
		logic             report_valid;
		logic             drive_down;
		logic             drive_up;
	} result_t;

	function automatic logic [PCT_W-1:0] sat_pct(input logic [RPCT_W-1:0] v);
		logic [PCT_W-1:0] r;
		if (v > RPCT_W'(PCT_MAX))
			r = PCT_W'(PCT_MAX);
		else
			r = v[PCT_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/rsmc_front.sv */
// Front end: accepts input beats, classifies them and queues them for the back end.
// Depends on rsmc_pkg.
`default_nettype none

module rsmc_front
	import rsmc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // mode[1:0], command[3:2], restore_pct[11:4]
	output logic             q_valid,
	output op_t              q_op,
	input  wire logic        q_pop
);

	localparam int QA_W = $clog2(QDEPTH);

	mode_t             mode;
	in_cmd_t           in_cmd;
	logic [RPCT_W-1:0] rpct;
	op_t               op_new;
	op_t               mem_q [QDEPTH];
	logic [QA_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QA_W:0]     cnt_q;
	logic              push;

	assign mode   = mode_t'(s_axis_tdata[1:0]);
	assign in_cmd = in_cmd_t'(s_axis_tdata[3:2]);
	assign rpct   = s_axis_tdata[11:4];

	always_comb begin
		op_new.cmd = CMD_NONE;
		op_new.pct = sat_pct(rpct);
		unique case (mode)
			MODE_TICK:    op_new.kind = OP_TICK;
			MODE_CMD:     op_new.kind = OP_CMD;
			MODE_RESTORE: op_new.kind = OP_RESTORE;
			default:      op_new.kind = OP_NOP;
		endcase
		unique case (in_cmd)
			IN_OPEN:  op_new.cmd = CMD_OPEN;
			IN_CLOSE: op_new.cmd = CMD_CLOSE;
			IN_STOP:  op_new.cmd = CMD_STOP;
			default:  op_new.cmd = CMD_NONE;
		endcase
	end

	assign s_axis_tready = (cnt_q != (QA_W+1)'(QDEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (cnt_q != '0);
	assign q_op          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= op_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && q_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/rsmc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rsmc_pkg.
`default_nettype none

module rsmc_div
	import rsmc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [CFG_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [CFG_W:0]   trial;
	logic [CFG_W:0]   diff;

	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// no borrow: the divisor fits, take the difference and shift in a one
			if (!diff[CFG_W]) begin
				rem_q <= diff[CFG_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CFG_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/rsmc_back.sv */
// Back end: configuration registers, motor state, tick sequencing and the result register.
// Depends on rsmc_pkg; drives rsmc_div through the start / done ports.
`default_nettype none

module rsmc_back
	import rsmc_pkg::*;
#(
	parameter int TICK_MS = TICK_MS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 q_valid,
	input  wire op_t                  q_op,
	output logic                      q_pop,
	output logic                      div_start,
	output logic [DIV_W-1:0]          div_dividend,
	output logic [CFG_W-1:0]          div_divisor,
	input  wire logic                 div_done,
	input  wire logic [DIV_W-1:0]     div_quo,
	output logic                      m_valid,
	input  wire logic                 m_ready,
	output result_t                   m_result
);

	logic [CFG_W-1:0] full_q, ov_q, rp_q;

	state_t                  state_q, state_d;
	cmd_t                    pend_q, pend_d, dir_q, dir_d;
	logic signed [POS_W-1:0] pos_q, pos_d, ct_q, ct_d, ot_q, ot_d;
	logic                    win_q, win_d, have_q, have_d, rst_op_q, rst_op_d;
	logic                    zero_q, zero_d;
	logic [PCT_W-1:0]        last_q, last_d, rpct_q, rpct_d;
	logic                    out_valid_q, out_valid_d;
	result_t                 out_q, out_d;

	logic signed [POS_W-1:0] tick_s, rp_s, hi_lim, lo_lim, full_s;
	// tick, first half: pause timers and pending command
	cmd_t                    tk_pend, tk_dir;
	logic signed [POS_W-1:0] tk_ct, tk_ot;
	// tick, second half: movement and end clamp
	cmd_t                    mv_dir;
	logic signed [POS_W-1:0] mv_pos;
	logic [PCT_W-1:0]        pct;

	assign tick_s = $signed(POS_W'(TICK_MS));
	assign rp_s   = $signed(POS_W'(rp_q));
	assign full_s = $signed(POS_W'(full_q));
	assign hi_lim = full_s + $signed(POS_W'(ov_q));
	assign lo_lim = -$signed(POS_W'(ov_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= FULL_TRAVEL_RST;
			ov_q   <= OVERRUN_RST;
			rp_q   <= REV_PAUSE_RST;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_FULL_TRAVEL: full_q <= cfg_wdata;
				REG_OVERRUN:     ov_q   <= cfg_wdata;
				REG_REV_PAUSE:   rp_q   <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	always_comb begin
		tk_pend = pend_q;
		tk_dir  = dir_q;
		tk_ct   = ct_q;
		tk_ot   = ot_q;
		if (tk_dir == CMD_OPEN)
			tk_ct = rp_s;
		if (tk_ct > 0)
			tk_ct = tk_ct - tick_s;
		else if (tk_pend == CMD_CLOSE) begin
			tk_pend = CMD_NONE;
			tk_dir  = CMD_CLOSE;
		end
		// sees a close just applied above, which restarts the open pause
		if (tk_dir == CMD_CLOSE)
			tk_ot = rp_s;
		if (tk_ot > 0)
			tk_ot = tk_ot - tick_s;
		else if (tk_pend == CMD_OPEN) begin
			tk_pend = CMD_NONE;
			tk_dir  = CMD_OPEN;
		end
		if (tk_pend != CMD_NONE)
			tk_dir = CMD_NONE;
		if (tk_pend == CMD_STOP)
			tk_pend = CMD_NONE;
	end

	always_comb begin
		mv_pos = pos_q;
		mv_dir = dir_q;
		if (dir_q == CMD_CLOSE) begin
			mv_pos = pos_q + tick_s;
			if (mv_pos >= hi_lim) begin
				mv_dir = CMD_NONE;
				mv_pos = full_s;
			end
		end
		if (mv_dir == CMD_OPEN) begin
			mv_pos = pos_q - tick_s;
			if (mv_pos <= lo_lim) begin
				mv_dir = CMD_NONE;
				mv_pos = '0;
			end
		end
	end

	always_comb begin
		if (zero_q)
			pct = '0;
		else if (div_quo > DIV_W'(PCT_MAX))
			pct = PCT_W'(PCT_MAX);
		else
			pct = div_quo[PCT_W-1:0];
	end

	always_comb begin
		state_d      = state_q;
		pend_d       = pend_q;
		dir_d        = dir_q;
		pos_d        = pos_q;
		ct_d         = ct_q;
		ot_d         = ot_q;
		win_d        = win_q;
		have_d       = have_q;
		last_d       = last_q;
		rst_op_d     = rst_op_q;
		zero_d       = zero_q;
		rpct_d       = rpct_q;
		out_valid_d  = out_valid_q;
		out_d        = out_q;
		q_pop        = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;

		if (out_valid_q && m_ready)
			out_valid_d = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && !out_valid_q) begin
					q_pop             = 1'b1;
					out_d.drive_up    = (dir_q == CMD_OPEN);
					out_d.drive_down  = (dir_q == CMD_CLOSE);
					out_d.report_valid = 1'b0;
					out_d.report_pct  = '0;
					unique case (q_op.kind)
						OP_TICK: begin
							pend_d  = tk_pend;
							dir_d   = tk_dir;
							ct_d    = tk_ct;
							ot_d    = tk_ot;
							state_d = ST_MOVE;
						end
						OP_CMD: begin
							win_d = 1'b0;
							if (q_op.cmd != CMD_NONE)
								pend_d = q_op.cmd;
							out_valid_d = 1'b1;
						end
						OP_RESTORE: begin
							if (win_q) begin
								rpct_d   = q_op.pct;
								rst_op_d = 1'b1;
								state_d  = ST_MUL;
							end else
								out_valid_d = 1'b1;
						end
						default: out_valid_d = 1'b1;
					endcase
				end
			end
			ST_MOVE: begin
				pos_d    = mv_pos;
				dir_d    = mv_dir;
				rst_op_d = 1'b0;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				if (rst_op_q) begin
					// restore: pct * full / 100
					div_start    = 1'b1;
					div_dividend = DIV_W'(rpct_q) * DIV_W'(full_q);
					div_divisor  = CFG_W'(PCT_MAX);
					zero_d       = 1'b0;
					state_d      = ST_DIV;
				end else if (full_q == '0 || pos_q <= 0) begin
					zero_d  = 1'b1;
					state_d = ST_FIN;
				end else begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(pos_q[MAG_W-1:0]) * DIV_W'(PCT_MAX);
					div_divisor  = full_q;
					zero_d       = 1'b0;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				out_d.drive_up     = (dir_q == CMD_OPEN);
				out_d.drive_down   = (dir_q == CMD_CLOSE);
				out_d.report_valid = 1'b0;
				out_d.report_pct   = '0;
				if (rst_op_q) begin
					pos_d = $signed(POS_W'(div_quo[CFG_W-1:0]));
					win_d = 1'b0;
				end else if (!win_q && (!have_q || pct != last_q)) begin
					have_d             = 1'b1;
					last_d             = pct;
					out_d.report_valid = 1'b1;
					out_d.report_pct   = pct;
				end
				out_valid_d = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= CMD_NONE;
			dir_q       <= CMD_NONE;
			pos_q       <= '0;
			ct_q        <= '0;
			ot_q        <= '0;
			win_q       <= 1'b1;
			have_q      <= 1'b0;
			last_q      <= '0;
			rst_op_q    <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q      <= pend_d;
			dir_q       <= dir_d;
			pos_q       <= pos_d;
			ct_q        <= ct_d;
			ot_q        <= ot_d;
			win_q       <= win_d;
			have_q      <= have_d;
			last_q      <= last_d;
			rst_op_q    <= rst_op_d;
			zero_q      <= zero_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		rpct_q <= rpct_d;
		out_q  <= out_d;
	end

	assign m_valid  = out_valid_q;
	assign m_result = out_q;

endmodule

`default_nettype wire

/* rtl/core/roller_shutter_motor_controller_top.sv */
// Roller shutter motor controller. A tick passes pop, move, divider start, divider steps,
// done and finish, or skips the divider if no divide is needed; a restore inside its
// window skips the move; commands, ignored items and late restores register their result at
// the pop. Throughput: one item at a time in the back end, the next popped the cycle after
// the result beat leaves; a two-beat queue in front keeps accepting meanwhile. Reset: arst_n
// clears only the control state at once; registers return to 30000 / 2000 / 500 ms.
`default_nettype none

module roller_shutter_motor_controller_top
	import rsmc_pkg::*;
#(
	parameter int TICK_MS = TICK_MS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [15:0]          s_axis_tdata,  // mode[1:0], command[3:2], restore_pct[11:4]
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [15:0]               m_axis_tdata,  // drive_up[0], drive_down[1],
	                                                 // report_valid[2], report_pct[9:3]
	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	logic             q_valid, q_pop;
	op_t              q_op;
	logic             div_start, div_done;
	logic [DIV_W-1:0] div_dividend, div_quo;
	logic [CFG_W-1:0] div_divisor;
	result_t          result;

	rsmc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_valid       (q_valid),
		.q_op          (q_op),
		.q_pop         (q_pop)
	);

	rsmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	rsmc_back #(
		.TICK_MS (TICK_MS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.q_valid      (q_valid),
		.q_op         (q_op),
		.q_pop        (q_pop),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quo      (div_quo),
		.m_valid      (m_axis_tvalid),
		.m_ready      (m_axis_tready),
		.m_result     (result)
	);

	assign m_axis_tdata = {6'b0, result};

endmodule

`default_nettype wire

/* dv/tb_roller_shutter_motor_controller_top.sv */
// Self-checking testbench for roller_shutter_motor_controller_top: directed table, then random
// command/tick bursts under several register settings, checked against an in-bench predictor.
// Depends on rsmc_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb_roller_shutter_motor_controller_top;
	import rsmc_pkg::*;

	localparam int          TICK_STEP_MS = 10;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int          HOLD_CYCLES  = 300;

	typedef struct packed {
		logic       up;
		logic       dn;
		logic       rv;
		logic [6:0] pct;
	} drive_report_t;

	typedef struct packed {
		mode_t         mode;
		in_cmd_t       cmd;
		logic [7:0]    rpct;
		logic          typed;
		drive_report_t res;
	} stim_row_t;

	localparam drive_report_t QUIET = '0;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [15:0]          m_axis_tdata;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_wdata;

	// predictor state
	int   full_ms, over_ms, rev_ms;
	cmd_t pend, dir;
	int   pos, tmr_close, tmr_open;
	bit   win, reported;
	int   last_pct;

	drive_report_t expected_drive_q[$];
	stim_row_t     dir_rows[$];
	bit            failed;
	bit            no_idle;
	bit            rx_hold_req;
	int            rx_hold_left;
	int unsigned   cyc;

	roller_shutter_motor_controller_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reversing: the opposite run reloads the pause, which must count out before engaging
	function automatic void pause_or_engage(cmd_t want, cmd_t opp, inout int tmr);
		if (dir == opp)
			tmr = rev_ms;
		if (tmr > 0) begin
			tmr -= TICK_STEP_MS;
			return;
		end
		if (pend == want) begin
			pend = CMD_NONE;
			dir  = want;
		end
	endfunction

	function automatic int closed_pct();
		int p;
		if (full_ms == 0 || pos <= 0)
			return 0;
		p = (pos * 100) / full_ms;
		return (p > 100) ? 100 : p;
	endfunction

	function automatic drive_report_t advance_shutter(mode_t m, in_cmd_t c, logic [7:0] rp);
		drive_report_t r;
		int            pct;
		int            sp;
		r = QUIET;
		case (m)
			MODE_CMD: begin
				win = 1'b0;
				case (c)
					IN_OPEN:  pend = CMD_OPEN;
					IN_CLOSE: pend = CMD_CLOSE;
					IN_STOP:  pend = CMD_STOP;
					default:  ;
				endcase
			end
			MODE_RESTORE: begin
				if (win) begin
					win = 1'b0;
					sp  = (rp > 8'd100) ? 100 : int'(rp);
					pos = (sp * full_ms) / 100;
				end
			end
			MODE_TICK: begin
				pause_or_engage(CMD_CLOSE, CMD_OPEN, tmr_close);
				pause_or_engage(CMD_OPEN, CMD_CLOSE, tmr_open);
				if (pend != CMD_NONE)
					dir = CMD_NONE;
				if (pend == CMD_STOP)
					pend = CMD_NONE;
				if (dir == CMD_CLOSE) begin
					pos += TICK_STEP_MS;
					if (pos >= full_ms + over_ms) begin
						dir = CMD_NONE;
						pos = full_ms;
					end
				end
				if (dir == CMD_OPEN) begin
					pos -= TICK_STEP_MS;
					if (pos <= -over_ms) begin
						dir = CMD_NONE;
						pos = 0;
					end
				end
				pct = closed_pct();
				if (!win && (!reported || pct != last_pct)) begin
					reported = 1'b1;
					last_pct = pct;
					r.rv     = 1'b1;
					r.pct    = pct[6:0];
				end
			end
			default: ;
		endcase
		r.up = (dir == CMD_OPEN);
		r.dn = (dir == CMD_CLOSE);
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_item(mode_t m, in_cmd_t c, logic [7:0] rp, logic typed,
	                         drive_report_t typed_res);
		drive_report_t pred;
		while (!no_idle && $urandom_range(0, 99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, rp, c, m};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = advance_shutter(m, c, rp);
		expected_drive_q.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_drive_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_regs(int full, int over, int rev, bit touch_unused);
		cfg_wen   <= 1'b1;
		cfg_addr  <= REG_FULL_TRAVEL;
		cfg_wdata <= full[15:0];
		@(negedge clk);
		cfg_addr  <= REG_OVERRUN;
		cfg_wdata <= over[15:0];
		@(negedge clk);
		cfg_addr  <= REG_REV_PAUSE;
		cfg_wdata <= rev[15:0];
		@(negedge clk);
		if (touch_unused) begin
			// unmapped index must not disturb anything
			cfg_addr  <= REG_UNUSED;
			cfg_wdata <= CFG_W'($urandom);
			@(negedge clk);
		end
		cfg_wen <= 1'b0;
		full_ms = full;
		over_ms = over;
		rev_ms  = rev;
	endtask

	// command followed by a run of ticks, with some ignored items mixed in
	task automatic run_bursts(int n_items);
		int done;
		int burst;
		int r;
		done = 0;
		while (done < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send_item(MODE_RSVD, in_cmd_t'($urandom_range(0, 3)),
				          8'($urandom_range(0, 255)), 1'b0, QUIET);
			end else if (r < 9) begin
				send_item(MODE_RESTORE, in_cmd_t'($urandom_range(0, 3)),
				          8'($urandom_range(0, 255)), 1'b0, QUIET);
			end else begin
				send_item(MODE_CMD, in_cmd_t'($urandom_range(0, 3)),
				          8'($urandom_range(0, 255)), 1'b0, QUIET);
				done++;
				burst = $urandom_range(0, 40);
				if (burst > n_items - done)
					burst = n_items - done;
				repeat (burst) begin
					send_item(MODE_TICK, in_cmd_t'($urandom_range(0, 3)),
					          8'($urandom_range(0, 255)), 1'b0, QUIET);
					done++;
				end
			end
		end
		wait_drained();
	endtask

	task automatic check_result(drive_report_t e, drive_report_t g);
		if (g.up !== e.up) begin
			$display("%0t mismatch drive_up: expected %0d, got %0d", $time, e.up, g.up);
			failed = 1'b1;
		end
		if (g.dn !== e.dn) begin
			$display("%0t mismatch drive_down: expected %0d, got %0d", $time, e.dn, g.dn);
			failed = 1'b1;
		end
		if (g.rv !== e.rv) begin
			$display("%0t mismatch report_valid: expected %0d, got %0d", $time, e.rv, g.rv);
			failed = 1'b1;
		end
		if (g.pct !== e.pct) begin
			$display("%0t mismatch report_pct: expected %0d, got %0d", $time, e.pct, g.pct);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		drive_report_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tdata[9:3]};
			if (expected_drive_q.size() == 0) begin
				$display("%0t unexpected beat: expected none, got %h", $time, m_axis_tdata);
				failed = 1'b1;
			end else begin
				check_result(expected_drive_q.pop_front(), got);
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left = HOLD_CYCLES;
			rx_hold_req  = 1'b0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 7);
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		int        k;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_wen       = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		failed        = 1'b0;
		no_idle       = 1'b0;
		rx_hold_req   = 1'b0;
		rx_hold_left  = 0;
		cyc           = 0;
		full_ms       = int'(FULL_TRAVEL_RST);
		over_ms       = int'(OVERRUN_RST);
		rev_ms        = int'(REV_PAUSE_RST);
		pend          = CMD_NONE;
		dir           = CMD_NONE;
		pos           = 0;
		tmr_close     = 0;
		tmr_open      = 0;
		win           = 1'b1;
		reported      = 1'b0;
		last_pct      = 0;

		// reset register values; restore window still open at the start
		dir_rows.push_back('{MODE_TICK,    IN_OPEN,    8'd0,   1'b1, QUIET});
		dir_rows.push_back('{MODE_RSVD,    IN_UNKNOWN, 8'd255, 1'b1, QUIET});
		dir_rows.push_back('{MODE_RESTORE, IN_OPEN,    8'd255, 1'b1, QUIET});
		dir_rows.push_back('{MODE_TICK,    IN_OPEN,    8'd0,   1'b1, '{1'b0, 1'b0, 1'b1, 7'd100}});
		dir_rows.push_back('{MODE_TICK,    IN_OPEN,    8'd0,   1'b1, QUIET});
		dir_rows.push_back('{MODE_RESTORE, IN_OPEN,    8'd0,   1'b1, QUIET});
		dir_rows.push_back('{MODE_CMD,     IN_OPEN,    8'd0,   1'b1, QUIET});
		dir_rows.push_back('{MODE_TICK,    IN_OPEN,    8'd0,   1'b1, '{1'b1, 1'b0, 1'b1, 7'd99}});
		dir_rows.push_back('{MODE_TICK,    IN_STOP,    8'd170, 1'b0, QUIET});
		dir_rows.push_back('{MODE_CMD,     IN_CLOSE,   8'd0,   1'b1, '{1'b1, 1'b0, 1'b0, 7'd0}});
		dir_rows.push_back('{MODE_TICK,    IN_OPEN,    8'd0,   1'b1, QUIET});
		dir_rows.push_back('{MODE_CMD,     IN_UNKNOWN, 8'd0,   1'b1, QUIET});
		dir_rows.push_back('{MODE_CMD,     IN_STOP,    8'd85,  1'b0, QUIET});
		dir_rows.push_back('{MODE_TICK,    IN_CLOSE,   8'd0,   1'b0, QUIET});
		dir_rows.push_back('{MODE_CMD,     IN_CLOSE,   8'd255, 1'b0, QUIET});
		dir_rows.push_back('{MODE_TICK,    IN_UNKNOWN, 8'd255, 1'b0, QUIET});
		dir_rows.push_back('{MODE_RSVD,    IN_OPEN,    8'd0,   1'b0, QUIET});
		dir_rows.push_back('{MODE_RESTORE, IN_CLOSE,   8'd100, 1'b0, QUIET});
		dir_rows.push_back('{MODE_TICK,    IN_OPEN,    8'd101, 1'b0, QUIET});

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < dir_rows.size(); k++) begin
			row = dir_rows[k];
			send_item(row.mode, row.cmd, row.rpct, row.typed, row.res);
		end
		wait_drained();

		// short travel so the ends and overruns are reached; no idling in this stretch
		no_idle = 1'b1;
		set_regs(200, 30, 20, 1'b0);
		run_bursts(80);
		no_idle = 1'b0;

		set_regs(0, 0, 0, 1'b1);
		run_bursts(50);

		set_regs(65535, 65535, 65535, 1'b0);
		run_bursts(40);

		for (k = 0; k < 6; k++) begin
			set_regs($urandom_range(0, 500), $urandom_range(0, 80), $urandom_range(0, 80),
			         k == 2);
			if (k == 0)
				rx_hold_req = 1'b1;
			run_bursts(60);
		end

		repeat (40) @(posedge clk);
		if (!failed && expected_drive_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
